// ===== src/kf_pkg.sv =====
// ----------------------------------------------------------------------------
// kf_pkg
// shared types, codes and the step program of the two-state kalman filter
// ----------------------------------------------------------------------------
package kf_pkg;

	localparam int COEF_FRAC = 12;

	// configuration register indexes
	localparam logic [2:0] REG_TRANS   = 3'd0;
	localparam logic [2:0] REG_HROW    = 3'd1;
	localparam logic [2:0] REG_RNOISE  = 3'd2;
	localparam logic [2:0] REG_QNOISEA = 3'd3;
	localparam logic [2:0] REG_QNOISEB = 3'd4;
	localparam logic [2:0] REG_XSTART  = 3'd5;
	localparam logic [2:0] REG_PSTARTA = 3'd6;
	localparam logic [2:0] REG_PSTARTB = 3'd7;

	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_NOT_POS = 2'd1;
	localparam logic [1:0] STAT_SAT     = 2'd2;

	localparam logic OP_RESTART = 1'b0;

	typedef enum logic [4:0] {
		OPD_ZERO, OPD_X0, OPD_X1, OPD_NX0, OPD_NX1,
		OPD_P00, OPD_P01, OPD_P10, OPD_P11,
		OPD_T00, OPD_T01, OPD_T10, OPD_T11,
		OPD_HP0, OPD_HP1, OPD_PH0, OPD_PH1,
		OPD_K0, OPD_K1, OPD_Y, OPD_S,
		OPD_A00, OPD_A01, OPD_A10, OPD_A11, OPD_H0, OPD_H1,
		OPD_Q00, OPD_Q01, OPD_Q11, OPD_Z, OPD_R
	} opnd_t;

	// clamp: clamp the shifted sum, add, clamp again
	// outer: add the unclamped shifted sum, then clamp
	// wide: add without any clamp (innovation variance)
	typedef enum logic [1:0] {
		MODE_CLAMP, MODE_OUTER, MODE_WIDE
	} mode_t;

	typedef enum logic [2:0] {
		K_MAC, K_COPYX, K_CHECK, K_DIV, K_DONE
	} kind_t;

	typedef struct packed {
		kind_t kind;
		opnd_t a0;
		opnd_t b0;
		opnd_t a1;
		opnd_t b1;
		logic  sh_f;
		mode_t mode;
		opnd_t add;
		logic  neg;
		opnd_t dst;
	} uop_t;

	typedef struct packed {
		logic  load;
		logic  add;
		logic  sh_f;
		mode_t mode;
		logic  neg;
	} mac_ctl_t;

	function automatic uop_t mac_u(opnd_t a0, opnd_t b0, opnd_t a1, opnd_t b1, logic sh_f,
			mode_t mode, opnd_t add, logic neg, opnd_t dst);
		uop_t u;
		u.kind = K_MAC;
		u.a0 = a0;
		u.b0 = b0;
		u.a1 = a1;
		u.b1 = b1;
		u.sh_f = sh_f;
		u.mode = mode;
		u.add = add;
		u.neg = neg;
		u.dst = dst;
		return u;
	endfunction

	function automatic uop_t ctl_u(kind_t kind, opnd_t a0, opnd_t dst);
		uop_t u;
		u = mac_u(a0, OPD_ZERO, OPD_ZERO, OPD_ZERO, 1'b0, MODE_CLAMP, OPD_ZERO, 1'b0, dst);
		u.kind = kind;
		return u;
	endfunction

	// measurement update program
	function automatic uop_t kf_uop(logic [4:0] idx);
		uop_t u;
		case (idx)
			// predict state into temporaries
			5'd0: u = mac_u(OPD_A00, OPD_X0, OPD_A01, OPD_X1, 1'b0, MODE_CLAMP, OPD_ZERO, 1'b0, OPD_NX0);
			5'd1: u = mac_u(OPD_A10, OPD_X0, OPD_A11, OPD_X1, 1'b0, MODE_CLAMP, OPD_ZERO, 1'b0, OPD_NX1);
			5'd2: u = ctl_u(K_COPYX, OPD_ZERO, OPD_ZERO);
			// t = a p
			5'd3: u = mac_u(OPD_A00, OPD_P00, OPD_A01, OPD_P10, 1'b0, MODE_CLAMP, OPD_ZERO, 1'b0, OPD_T00);
			5'd4: u = mac_u(OPD_A00, OPD_P01, OPD_A01, OPD_P11, 1'b0, MODE_CLAMP, OPD_ZERO, 1'b0, OPD_T01);
			5'd5: u = mac_u(OPD_A10, OPD_P00, OPD_A11, OPD_P10, 1'b0, MODE_CLAMP, OPD_ZERO, 1'b0, OPD_T10);
			5'd6: u = mac_u(OPD_A10, OPD_P01, OPD_A11, OPD_P11, 1'b0, MODE_CLAMP, OPD_ZERO, 1'b0, OPD_T11);
			// p = t a' + q
			5'd7: u = mac_u(OPD_T00, OPD_A00, OPD_T01, OPD_A01, 1'b0, MODE_CLAMP, OPD_Q00, 1'b0, OPD_P00);
			5'd8: u = mac_u(OPD_T00, OPD_A10, OPD_T01, OPD_A11, 1'b0, MODE_CLAMP, OPD_Q01, 1'b0, OPD_P01);
			5'd9: u = mac_u(OPD_T10, OPD_A00, OPD_T11, OPD_A01, 1'b0, MODE_CLAMP, OPD_Q01, 1'b0, OPD_P10);
			5'd10: u = mac_u(OPD_T10, OPD_A10, OPD_T11, OPD_A11, 1'b0, MODE_CLAMP, OPD_Q11, 1'b0, OPD_P11);
			// h p and p h'
			5'd11: u = mac_u(OPD_H0, OPD_P00, OPD_H1, OPD_P10, 1'b0, MODE_CLAMP, OPD_ZERO, 1'b0, OPD_HP0);
			5'd12: u = mac_u(OPD_H0, OPD_P01, OPD_H1, OPD_P11, 1'b0, MODE_CLAMP, OPD_ZERO, 1'b0, OPD_HP1);
			5'd13: u = mac_u(OPD_P00, OPD_H0, OPD_P01, OPD_H1, 1'b0, MODE_CLAMP, OPD_ZERO, 1'b0, OPD_PH0);
			5'd14: u = mac_u(OPD_P10, OPD_H0, OPD_P11, OPD_H1, 1'b0, MODE_CLAMP, OPD_ZERO, 1'b0, OPD_PH1);
			5'd15: u = mac_u(OPD_HP0, OPD_H0, OPD_HP1, OPD_H1, 1'b0, MODE_WIDE, OPD_R, 1'b0, OPD_S);
			5'd16: u = ctl_u(K_CHECK, OPD_ZERO, OPD_ZERO);
			5'd17: u = ctl_u(K_DIV, OPD_PH0, OPD_K0);
			5'd18: u = ctl_u(K_DIV, OPD_PH1, OPD_K1);
			// innovation
			5'd19: u = mac_u(OPD_H0, OPD_X0, OPD_H1, OPD_X1, 1'b0, MODE_CLAMP, OPD_Z, 1'b1, OPD_Y);
			// correction
			5'd20: u = mac_u(OPD_K0, OPD_Y, OPD_ZERO, OPD_ZERO, 1'b1, MODE_OUTER, OPD_X0, 1'b0, OPD_X0);
			5'd21: u = mac_u(OPD_K1, OPD_Y, OPD_ZERO, OPD_ZERO, 1'b1, MODE_OUTER, OPD_X1, 1'b0, OPD_X1);
			5'd22: u = mac_u(OPD_K0, OPD_HP0, OPD_ZERO, OPD_ZERO, 1'b1, MODE_OUTER, OPD_P00, 1'b1, OPD_P00);
			5'd23: u = mac_u(OPD_K0, OPD_HP1, OPD_ZERO, OPD_ZERO, 1'b1, MODE_OUTER, OPD_P01, 1'b1, OPD_P01);
			5'd24: u = mac_u(OPD_K1, OPD_HP0, OPD_ZERO, OPD_ZERO, 1'b1, MODE_OUTER, OPD_P10, 1'b1, OPD_P10);
			5'd25: u = mac_u(OPD_K1, OPD_HP1, OPD_ZERO, OPD_ZERO, 1'b1, MODE_OUTER, OPD_P11, 1'b1, OPD_P11);
			default: u = ctl_u(K_DONE, OPD_ZERO, OPD_ZERO);
		endcase
		return u;
	endfunction

endpackage

// ===== src/kalman_filter_step.sv =====
// ----------------------------------------------------------------------------
// kalman_filter_step
// two-state, one-measurement linear kalman filter step in fixed point
//
// channel   direction  payload
// s_*       in         tuser: op; tdata[31:0]: measurement
// m_*       out        tdata[31:0] est_first, [63:32] est_second, [65:64] status
// cfg_*     in         cfg_index selects register, cfg_data written when cfg_we
//
// a restart goes from idle straight to the finish state, which loads the
// output register; a measurement update makes 22 passes through the
// shared multiplier plus two bit-serial divisions.
// s_tready is high only while no item is in progress; a held result does
// not stop the next item from being taken, only from finishing.
// arst_n loads the identity transition matrix, zeroes all but the scratch.
// ----------------------------------------------------------------------------
module kalman_filter_step import kf_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // measurement
	input  logic        s_tuser,   // op
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,   // est_first, est_second, status, zero fill
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	typedef enum logic [1:0] {S_IDLE, S_RUN, S_DIV, S_FIN} state_t;

	state_t      state_q;
	logic [4:0]  idx_q;
	logic [1:0]  phase_q;
	logic        sat_q;
	logic [1:0]  status_q;
	logic        m_tvalid_q;
	logic [31:0] out_first_q, out_second_q;
	logic [1:0]  out_status_q;

	logic [63:0] trans_q, qa_q, xst_q, pa_q;
	logic [31:0] hrow_q, rn_q, qb_q, pb_q;

	logic signed [31:0] x0_q, x1_q, p00_q, p01_q, p10_q, p11_q;
	logic signed [31:0] nx0_q, nx1_q, t00_q, t01_q, t10_q, t11_q;
	logic signed [31:0] hp0_q, hp1_q, ph0_q, ph1_q, k0_q, k1_q, y_q, z_q;
	logic        [39:0] s_q;

	uop_t               uop;
	mac_ctl_t           mctl;
	logic signed [31:0] opa, opb, mac_res, div_quot;
	logic signed [32:0] addend;
	logic        [39:0] mac_wide;
	logic               mac_sat, div_done, div_sat, div_start;
	logic               mac_wr, wr_en, accept, out_free;
	logic signed [31:0] wr_val;

	function automatic logic signed [32:0] opnd(opnd_t c);
		logic signed [32:0] v;
		case (c)
			OPD_X0:  v = 33'(x0_q);
			OPD_X1:  v = 33'(x1_q);
			OPD_NX0: v = 33'(nx0_q);
			OPD_NX1: v = 33'(nx1_q);
			OPD_P00: v = 33'(p00_q);
			OPD_P01: v = 33'(p01_q);
			OPD_P10: v = 33'(p10_q);
			OPD_P11: v = 33'(p11_q);
			OPD_T00: v = 33'(t00_q);
			OPD_T01: v = 33'(t01_q);
			OPD_T10: v = 33'(t10_q);
			OPD_T11: v = 33'(t11_q);
			OPD_HP0: v = 33'(hp0_q);
			OPD_HP1: v = 33'(hp1_q);
			OPD_PH0: v = 33'(ph0_q);
			OPD_PH1: v = 33'(ph1_q);
			OPD_K0:  v = 33'(k0_q);
			OPD_K1:  v = 33'(k1_q);
			OPD_Y:   v = 33'(y_q);
			OPD_A00: v = 33'($signed(trans_q[15:0]));
			OPD_A01: v = 33'($signed(trans_q[31:16]));
			OPD_A10: v = 33'($signed(trans_q[47:32]));
			OPD_A11: v = 33'($signed(trans_q[63:48]));
			OPD_H0:  v = 33'($signed(hrow_q[15:0]));
			OPD_H1:  v = 33'($signed(hrow_q[31:16]));
			OPD_Q00: v = 33'($signed(qa_q[31:0]));
			OPD_Q01: v = 33'($signed(qa_q[63:32]));
			OPD_Q11: v = 33'($signed(qb_q));
			OPD_Z:   v = 33'(z_q);
			OPD_R:   v = $signed({1'b0, rn_q});
			default: v = '0;
		endcase
		return v;
	endfunction

	assign uop = kf_uop(idx_q);
	assign accept = s_tvalid && s_tready;
	assign s_tready = (state_q == S_IDLE);
	assign out_free = !m_tvalid_q || m_tready;

	always_comb begin
		logic signed [32:0] va, vb;
		va = (phase_q == 2'd0) ? opnd(uop.a0) : opnd(uop.a1);
		vb = (phase_q == 2'd0) ? opnd(uop.b0) : opnd(uop.b1);
		opa = va[31:0];
		opb = vb[31:0];
	end

	assign addend = opnd(uop.add);
	assign mac_wr = (state_q == S_RUN) && (uop.kind == K_MAC) && (phase_q == 2'd3);
	assign wr_en = mac_wr || ((state_q == S_DIV) && div_done);
	assign wr_val = mac_wr ? mac_res : div_quot;
	assign div_start = (state_q == S_RUN) && (uop.kind == K_DIV);

	always_comb begin
		mctl.load = (state_q == S_RUN) && (uop.kind == K_MAC) && (phase_q == 2'd1);
		mctl.add = (state_q == S_RUN) && (uop.kind == K_MAC) && (phase_q == 2'd2);
		mctl.sh_f = uop.sh_f;
		mctl.mode = uop.mode;
		mctl.neg = uop.neg;
	end

	kf_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
		.clk      (clk),
		.ctl      (mctl),
		.opa      (opa),
		.opb      (opb),
		.addend   (addend),
		.res      (mac_res),
		.res_wide (mac_wide),
		.sat      (mac_sat)
	);

	kf_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (opa),
		.den    (s_q),
		.done   (div_done),
		.quot   (div_quot),
		.sat    (div_sat)
	);

	// scratch values of one update
	always_ff @(posedge clk) begin
		if (accept) begin
			z_q <= $signed(s_tdata);
		end
		if (mac_wr && uop.dst == OPD_S) begin
			s_q <= mac_wide;
		end
		if (wr_en) begin
			case (uop.dst)
				OPD_NX0: nx0_q <= wr_val;
				OPD_NX1: nx1_q <= wr_val;
				OPD_T00: t00_q <= wr_val;
				OPD_T01: t01_q <= wr_val;
				OPD_T10: t10_q <= wr_val;
				OPD_T11: t11_q <= wr_val;
				OPD_HP0: hp0_q <= wr_val;
				OPD_HP1: hp1_q <= wr_val;
				OPD_PH0: ph0_q <= wr_val;
				OPD_PH1: ph1_q <= wr_val;
				OPD_K0:  k0_q <= wr_val;
				OPD_K1:  k1_q <= wr_val;
				OPD_Y:   y_q <= wr_val;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q <= '0;
			phase_q <= '0;
			sat_q <= 1'b0;
			status_q <= STAT_OK;
			m_tvalid_q <= 1'b0;
			out_first_q <= '0;
			out_second_q <= '0;
			out_status_q <= STAT_OK;
			trans_q <= 64'h1000_0000_0000_1000;
			hrow_q <= '0;
			rn_q <= '0;
			qa_q <= '0;
			qb_q <= '0;
			xst_q <= '0;
			pa_q <= '0;
			pb_q <= '0;
			x0_q <= '0;
			x1_q <= '0;
			p00_q <= '0;
			p01_q <= '0;
			p10_q <= '0;
			p11_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_TRANS:   trans_q <= cfg_data;
					REG_HROW:    hrow_q <= cfg_data[31:0];
					REG_RNOISE:  rn_q <= cfg_data[31:0];
					REG_QNOISEA: qa_q <= cfg_data;
					REG_QNOISEB: qb_q <= cfg_data[31:0];
					REG_XSTART:  xst_q <= cfg_data;
					REG_PSTARTA: pa_q <= cfg_data;
					REG_PSTARTB: pb_q <= cfg_data[31:0];
					default: ;
				endcase
			end

			// in the finish state the output register is reloaded below
			if (m_tvalid_q && m_tready && state_q != S_FIN) begin
				m_tvalid_q <= 1'b0;
			end

			if (wr_en) begin
				case (uop.dst)
					OPD_X0:  x0_q <= wr_val;
					OPD_X1:  x1_q <= wr_val;
					OPD_P00: p00_q <= wr_val;
					OPD_P01: p01_q <= wr_val;
					OPD_P10: p10_q <= wr_val;
					OPD_P11: p11_q <= wr_val;
					default: ;
				endcase
				sat_q <= sat_q || (mac_wr ? mac_sat : div_sat);
			end

			case (state_q)
				S_IDLE: begin
					phase_q <= '0;
					idx_q <= '0;
					sat_q <= 1'b0;
					if (accept) begin
						if (s_tuser == OP_RESTART) begin
							x0_q <= $signed(xst_q[31:0]);
							x1_q <= $signed(xst_q[63:32]);
							p00_q <= $signed(pa_q[31:0]);
							p01_q <= $signed(pa_q[63:32]);
							p10_q <= $signed(pa_q[63:32]);
							p11_q <= $signed(pb_q);
							status_q <= STAT_OK;
							state_q <= S_FIN;
						end else begin
							state_q <= S_RUN;
						end
					end
				end
				S_RUN: begin
					case (uop.kind)
						K_MAC: begin
							phase_q <= phase_q + 1'b1;
							if (phase_q == 2'd3) idx_q <= idx_q + 1'b1;
						end
						K_COPYX: begin
							x0_q <= nx0_q;
							x1_q <= nx1_q;
							idx_q <= idx_q + 1'b1;
						end
						K_CHECK: begin
							// non-positive innovation variance skips the correction
							if ($signed(s_q) <= 40'sd0) begin
								status_q <= STAT_NOT_POS;
								state_q <= S_FIN;
							end else begin
								idx_q <= idx_q + 1'b1;
							end
						end
						K_DIV: begin
							state_q <= S_DIV;
						end
						default: begin
							status_q <= sat_q ? STAT_SAT : STAT_OK;
							state_q <= S_FIN;
						end
					endcase
				end
				S_DIV: begin
					if (div_done) begin
						idx_q <= idx_q + 1'b1;
						state_q <= S_RUN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						out_first_q <= x0_q;
						out_second_q <= x1_q;
						out_status_q <= status_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = {6'd0, out_status_q, out_second_q, out_first_q};

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[65:64] != 2'd3))
		else $error("reserved status code on output");

	a_not_pos_cause: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && out_free && status_q == STAT_NOT_POS) |-> ($signed(s_q) <= 40'sd0))
		else $error("not-positive status with positive innovation variance");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DIV))
		else $error("division finished outside its wait state");

	a_div_start_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |=> (state_q == S_DIV && !div_done))
		else $error("division start did not enter wait");

	a_idle_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |=> (phase_q == 2'd0))
		else $error("mac phase left running after idle");

endmodule

// ===== src/kf_mac.sv =====
// ----------------------------------------------------------------------------
// kf_mac
// shared multiply-accumulate with rescaling shift, addend and clamping
// ----------------------------------------------------------------------------
module kf_mac import kf_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  mac_ctl_t           ctl,
	input  logic signed [31:0] opa,
	input  logic signed [31:0] opb,
	input  logic signed [32:0] addend,
	output logic signed [31:0] res,
	output logic        [39:0] res_wide,
	output logic               sat
);

	localparam logic signed [64:0] MAX_V = 65'sd2147483647;
	localparam logic signed [64:0] MIN_V = -65'sd2147483648;
	localparam logic signed [65:0] MAX_S = 66'sd2147483647;
	localparam logic signed [65:0] MIN_S = -66'sd2147483648;

	logic signed [63:0] prod_s1;
	logic signed [64:0] acc_q;
	logic signed [64:0] v;
	logic signed [64:0] w;
	logic signed [64:0] t;
	logic signed [65:0] sum;
	logic               in_hi, in_lo, out_hi, out_lo;

	always_ff @(posedge clk) begin
		prod_s1 <= opa * opb;
		if (ctl.load) begin
			acc_q <= 65'(prod_s1);
		end else if (ctl.add) begin
			acc_q <= acc_q + 65'(prod_s1);
		end
	end

	always_comb begin
		v = ctl.sh_f ? (acc_q >>> FRAC_BITS) : (acc_q >>> COEF_FRAC);
		in_hi = v > MAX_V;
		in_lo = v < MIN_V;
		w = v;
		if (ctl.mode == MODE_CLAMP) begin
			if (in_hi) w = MAX_V;
			else if (in_lo) w = MIN_V;
		end
		t = ctl.neg ? -w : w;
		sum = 66'(addend) + 66'(t);
		out_hi = sum > MAX_S;
		out_lo = sum < MIN_S;
		if (out_hi) res = 32'sh7FFFFFFF;
		else if (out_lo) res = 32'sh80000000;
		else res = sum[31:0];
		res_wide = sum[39:0];
		sat = ((ctl.mode == MODE_CLAMP) && (in_hi || in_lo))
			|| ((ctl.mode != MODE_WIDE) && (out_hi || out_lo));
	end

endmodule

// ===== src/kf_div.sv =====
// ----------------------------------------------------------------------------
// kf_div
// bit-serial restoring divider for the gain, one quotient bit a cycle
// ----------------------------------------------------------------------------
module kf_div #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [31:0] num,
	input  logic        [39:0] den,
	output logic               done,
	output logic signed [31:0] quot,
	output logic               sat
);

	localparam int NB = 32 + FRAC_BITS;
	localparam int CW = $clog2(NB + 1);
	localparam logic [NB-1:0] QMAX_POS = NB'(33'h07FFFFFFF);
	localparam logic [NB-1:0] QMAX_NEG = NB'(33'h080000000);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [NB-1:0] dvd_q;
	logic [NB-1:0] quo_q;
	logic [39:0]   rem_q;
	logic [39:0]   den_q;
	logic          neg_q;
	logic [32:0]   mag;
	logic [40:0]   trial;
	logic          ge;
	logic          over;

	assign mag = num[31] ? -33'(num) : 33'(num);
	assign trial = {rem_q, dvd_q[NB-1]};
	assign ge = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(NB);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= {mag[31:0], {FRAC_BITS{1'b0}}};
			quo_q <= '0;
			rem_q <= '0;
			den_q <= den;
			neg_q <= num[31];
		end else if (busy_q) begin
			rem_q <= ge ? 40'(trial - {1'b0, den_q}) : trial[39:0];
			dvd_q <= dvd_q << 1;
			quo_q <= {quo_q[NB-2:0], ge};
		end
	end

	always_comb begin
		over = neg_q ? (quo_q > QMAX_NEG) : (quo_q > QMAX_POS);
		if (neg_q) quot = over ? 32'sh80000000 : -$signed(quo_q[31:0]);
		else quot = over ? 32'sh7FFFFFFF : $signed(quo_q[31:0]);
	end

	assign done = done_q;
	assign sat = over;

endmodule

// ===== tb/sv/kalman_filter_step_test.sv =====
// ----------------------------------------------------------------------------
// kalman_filter_step_test
// checks the two-state kalman filter step against a fixed-point predictor
//
// restarts and measurement updates stream in under random idling on both
// sides; every result is compared field by field with the predicted state
// and status. the filter matrices are rewritten between phases while idle.
// ----------------------------------------------------------------------------
module kalman_filter_step_test;
	import kf_pkg::*;

	typedef struct {
		logic        op;
		logic [31:0] z;
	} meas_item_t;

	typedef struct {
		logic [31:0] e0;
		logic [31:0] e1;
		logic [1:0]  st;
	} estimate_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [71:0] m_tdata;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [63:0] cfg_data = '0;

	kalman_filter_step dut (.*);

	always #6 clk = ~clk;

	// predictor copy of registers and filter state
	logic [63:0]    kf_reg [8];
	logic signed [63:0] xs [2];
	logic signed [63:0] pc [4];
	bit             clamped;

	meas_item_t pending_meas [$];
	estimate_t  expected_est [$];
	int         mismatches = 0;
	int         quiet_cycles = 0;
	bit         calm = 1'b0;
	int         accepted = 0;

	function automatic logic signed [63:0] fshift(logic signed [63:0] v, int s);
		return v >>> s;
	endfunction

	function automatic logic signed [63:0] sat32(logic signed [63:0] v);
		if (v > 64'sd2147483647) begin
			clamped = 1'b1;
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			clamped = 1'b1;
			return -64'sd2147483648;
		end
		return v;
	endfunction

	function automatic logic signed [63:0] acoef(int i, int j);
		return 64'(signed'(kf_reg[REG_TRANS][16*(2*i+j) +: 16]));
	endfunction

	function automatic logic signed [63:0] hcoef(int k);
		return 64'(signed'(kf_reg[REG_HROW][16*k +: 16]));
	endfunction

	function automatic logic signed [63:0] qcoef(int i, int j);
		if (i == 0 && j == 0) return 64'(signed'(kf_reg[REG_QNOISEA][31:0]));
		if (i == 1 && j == 1) return 64'(signed'(kf_reg[REG_QNOISEB][31:0]));
		return 64'(signed'(kf_reg[REG_QNOISEA][63:32]));
	endfunction

	function automatic estimate_t filter_step(meas_item_t it);
		estimate_t r;
		logic signed [63:0] nx [2];
		logic signed [63:0] t [4];
		logic signed [63:0] hp [2];
		logic signed [63:0] ph [2];
		logic signed [63:0] kg [2];
		logic signed [63:0] acc, s, y, z;
		r.st = STAT_OK;
		clamped = 1'b0;
		if (it.op == OP_RESTART) begin
			xs[0] = 64'(signed'(kf_reg[REG_XSTART][31:0]));
			xs[1] = 64'(signed'(kf_reg[REG_XSTART][63:32]));
			pc[0] = 64'(signed'(kf_reg[REG_PSTARTA][31:0]));
			pc[1] = 64'(signed'(kf_reg[REG_PSTARTA][63:32]));
			pc[2] = pc[1];
			pc[3] = 64'(signed'(kf_reg[REG_PSTARTB][31:0]));
		end else begin
			z = 64'(signed'(it.z));
			for (int i = 0; i < 2; i++)
				nx[i] = sat32(fshift(acoef(i, 0) * xs[0] + acoef(i, 1) * xs[1], COEF_FRAC));
			xs[0] = nx[0];
			xs[1] = nx[1];
			for (int i = 0; i < 2; i++)
				for (int j = 0; j < 2; j++)
					t[2*i+j] = sat32(fshift(acoef(i, 0) * pc[j] + acoef(i, 1) * pc[2+j],
						COEF_FRAC));
			for (int i = 0; i < 2; i++)
				for (int j = 0; j < 2; j++) begin
					acc = sat32(fshift(t[2*i] * acoef(j, 0) + t[2*i+1] * acoef(j, 1),
						COEF_FRAC));
					pc[2*i+j] = sat32(acc + qcoef(i, j));
				end
			for (int j = 0; j < 2; j++)
				hp[j] = sat32(fshift(hcoef(0) * pc[j] + hcoef(1) * pc[2+j], COEF_FRAC));
			for (int i = 0; i < 2; i++)
				ph[i] = sat32(fshift(pc[2*i] * hcoef(0) + pc[2*i+1] * hcoef(1), COEF_FRAC));
			s = fshift(hp[0] * hcoef(0) + hp[1] * hcoef(1), COEF_FRAC)
				+ 64'(kf_reg[REG_RNOISE][31:0]);
			if (s <= 0) begin
				r.st = STAT_NOT_POS;
			end else begin
				for (int i = 0; i < 2; i++)
					kg[i] = sat32((ph[i] * 64'sd65536) / s);
				acc = hcoef(0) * xs[0] + hcoef(1) * xs[1];
				y = sat32(z - sat32(fshift(acc, COEF_FRAC)));
				for (int i = 0; i < 2; i++)
					xs[i] = sat32(xs[i] + fshift(kg[i] * y, 16));
				for (int i = 0; i < 2; i++)
					for (int j = 0; j < 2; j++)
						pc[2*i+j] = sat32(pc[2*i+j] - fshift(kg[i] * hp[j], 16));
				if (clamped) r.st = STAT_SAT;
			end
		end
		r.e0 = xs[0][31:0];
		r.e1 = xs[1][31:0];
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h expected %h", what, got, want);
		mismatches++;
	endtask

	// driver
	always @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			expected_est.push_back(filter_step('{op: s_tuser, z: s_tdata}));
			accepted++;
		end
		if (!s_tvalid || s_tready) begin
			if (pending_meas.size() > 0 && (calm || $urandom_range(99) >= 23)) begin
				s_tvalid <= 1'b1;
				s_tuser <= pending_meas[0].op;
				s_tdata <= pending_meas[0].z;
				void'(pending_meas.pop_front());
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		estimate_t w;
		if (m_tvalid && m_tready) begin
			if (expected_est.size() == 0) begin
				report_mismatch("unexpected transaction", m_tdata[31:0], 32'h0);
			end else begin
				w = expected_est.pop_front();
				if (m_tdata[31:0] !== w.e0) report_mismatch("est_first", m_tdata[31:0], w.e0);
				if (m_tdata[63:32] !== w.e1)
					report_mismatch("est_second", m_tdata[63:32], w.e1);
				if (m_tdata[65:64] !== w.st)
					report_mismatch("status", 32'(m_tdata[65:64]), 32'(w.st));
			end
		end
		m_tready <= calm || $urandom_range(99) >= 23;
	end

	// watchdog
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > 20000) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [63:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_TRANS, REG_QNOISEA, REG_XSTART, REG_PSTARTA: kf_reg[idx] = val;
			default: kf_reg[idx] = {32'h0, val[31:0]};
		endcase
	endtask

	task automatic drain;
		while (pending_meas.size() > 0 || s_tvalid || expected_est.size() > 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	function automatic logic [15:0] small_coef();
		return 16'($signed($urandom_range(8192)) - 4096);
	endfunction

	function automatic logic [31:0] small_val();
		return 32'($signed($urandom_range(1 << 22)) - (1 << 21));
	endfunction

	// random realistic setting: moderate coefficients, non-negative noise
	task automatic random_setting;
		write_reg(REG_TRANS, {small_coef(), small_coef(), small_coef(), small_coef()});
		write_reg(REG_HROW, {small_coef(), small_coef()});
		write_reg(REG_RNOISE, 64'($urandom_range(1 << 20)));
		write_reg(REG_QNOISEA, {small_val(), 32'($urandom_range(1 << 18))});
		write_reg(REG_QNOISEB, 64'($urandom_range(1 << 18)));
		write_reg(REG_XSTART, {small_val(), small_val()});
		write_reg(REG_PSTARTA, {small_val(), 32'($urandom_range(1 << 20))});
		write_reg(REG_PSTARTB, 64'($urandom_range(1 << 20)));
	endtask

	task automatic queue_run(int n, bit wild);
		meas_item_t it;
		for (int i = 0; i < n; i++) begin
			it.op = (i == 0 || $urandom_range(15) == 0) ? OP_RESTART : ~OP_RESTART;
			it.z = wild ? $urandom() : small_val();
			pending_meas.push_back(it);
		end
	endtask

	initial begin
		kf_reg[REG_TRANS] = 64'h1000000000001000;
		for (int i = 1; i < 8; i++) kf_reg[i] = '0;
		for (int i = 0; i < 2; i++) xs[i] = 0;
		for (int i = 0; i < 4; i++) pc[i] = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		// reset defaults: zero covariance and noise gives s not positive
		pending_meas.push_back('{op: ~OP_RESTART, z: 32'h7fffffff});
		pending_meas.push_back('{op: OP_RESTART, z: 32'h80000000});
		drain();
		// directed: identity filter, unit h, extremes of measurement
		write_reg(REG_HROW, 64'h00000000_00001000);
		write_reg(REG_RNOISE, 64'h0001_0000);
		write_reg(REG_QNOISEA, 64'h0000_0000_0000_1000);
		write_reg(REG_QNOISEB, 64'h0000_1000);
		write_reg(REG_XSTART, 64'h0002_0000_fffe_0000);
		write_reg(REG_PSTARTA, 64'h0000_0000_0001_0000);
		write_reg(REG_PSTARTB, 64'h0001_0000);
		pending_meas.push_back('{op: OP_RESTART, z: 32'h0});
		pending_meas.push_back('{op: ~OP_RESTART, z: 32'h7fffffff});
		pending_meas.push_back('{op: ~OP_RESTART, z: 32'h80000000});
		pending_meas.push_back('{op: ~OP_RESTART, z: 32'h0});
		pending_meas.push_back('{op: ~OP_RESTART, z: 32'hffffffff});
		drain();
		// saturation: extreme matrix and start values
		write_reg(REG_TRANS, 64'h7fff_8000_8000_7fff);
		write_reg(REG_HROW, 64'h7fff_8000);
		write_reg(REG_RNOISE, 64'hffff_ffff);
		write_reg(REG_QNOISEA, 64'h7fff_ffff_8000_0000);
		write_reg(REG_QNOISEB, 64'h7fff_ffff);
		write_reg(REG_XSTART, 64'h8000_0000_7fff_ffff);
		write_reg(REG_PSTARTA, 64'h8000_0000_7fff_ffff);
		write_reg(REG_PSTARTB, 64'h8000_0000);
		pending_meas.push_back('{op: OP_RESTART, z: 32'h0});
		for (int i = 0; i < 4; i++) pending_meas.push_back('{op: ~OP_RESTART, z: $urandom()});
		drain();
		// negative innovation variance with zero r
		write_reg(REG_RNOISE, 64'h0);
		write_reg(REG_PSTARTA, 64'h0000_0000_8000_0000);
		write_reg(REG_TRANS, 64'h1000_0000_0000_1000);
		pending_meas.push_back('{op: OP_RESTART, z: 32'h0});
		pending_meas.push_back('{op: ~OP_RESTART, z: 32'h1234_5678});
		drain();
		// random phases, one calm stretch
		for (int ph = 0; ph < 10; ph++) begin
			random_setting();
			calm = (ph == 4);
			queue_run(70, ph % 3 == 2);
			drain();
		end
		calm = 1'b0;
		if (mismatches == 0 && expected_est.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

// ===== files.f =====
src/kf_pkg.sv
src/kf_mac.sv
src/kf_div.sv
src/kalman_filter_step.sv
tb/sv/kalman_filter_step_test.sv
